// ===== rtl/chd_pkg.sv =====
// shared types, constants and the cordic angle table for the compass heading block
`timescale 1ns / 1ps

package chd_pkg;

   localparam int SAMPLE_BITS       = 16;
   localparam int CORDIC_ITERATIONS = 16;
   localparam int SAMPLE_WIDTH      = 16;
   localparam int DIFF_BITS         = SAMPLE_BITS + 1;
   localparam int PROD_WIDTH        = 2 * DIFF_BITS;
   localparam int FRAC_BITS         = 16;
   localparam int CORDIC_WIDTH      = PROD_WIDTH + FRAC_BITS + 3;
   localparam int Z_WIDTH           = 27;
   localparam int DEG_WIDTH         = 11;
   localparam int HEADING_BITS      = 9;
   localparam int ANGLE_BITS        = 22;
   localparam int STEP_BITS         = 5;

   localparam logic [15:0]                CALIB_RESET  = 16'd3000;
   localparam logic signed [SAMPLE_BITS-1:0] MAX_RESET = -16'sd1000;
   localparam logic signed [SAMPLE_BITS-1:0] MIN_RESET = 16'sd1000;
   localparam logic signed [Z_WIDTH-1:0]  HALF_TURN    = 27'sd11796480;
   localparam logic signed [DEG_WIDTH-1:0] FULL_CIRCLE = 11'sd360;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x_raw;
      logic signed [SAMPLE_BITS-1:0] y_raw;
   } req_type;

   typedef struct packed {
      logic [HEADING_BITS-1:0] heading_deg;
      logic                    heading_valid;
   } rsp_type;

   // atan(2^-i) in degrees, 16 fractional bits, truncated
   function automatic logic [ANGLE_BITS-1:0] atan_deg(input logic [STEP_BITS-1:0] step);
      logic [ANGLE_BITS-1:0] val;
      case (step)
         5'd0:    val = 22'd2949120;
         5'd1:    val = 22'd1740967;
         5'd2:    val = 22'd919879;
         5'd3:    val = 22'd466945;
         5'd4:    val = 22'd234378;
         5'd5:    val = 22'd117303;
         5'd6:    val = 22'd58666;
         5'd7:    val = 22'd29334;
         5'd8:    val = 22'd14667;
         5'd9:    val = 22'd7333;
         5'd10:   val = 22'd3666;
         5'd11:   val = 22'd1833;
         5'd12:   val = 22'd916;
         5'd13:   val = 22'd458;
         5'd14:   val = 22'd229;
         5'd15:   val = 22'd114;
         5'd16:   val = 22'd57;
         5'd17:   val = 22'd28;
         5'd18:   val = 22'd14;
         5'd19:   val = 22'd7;
         5'd20:   val = 22'd3;
         5'd21:   val = 22'd1;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/chd_cordic.sv =====
// iterative vectoring cordic: angle of (px, py) in whole degrees 0..359
`timescale 1ns / 1ps

module chd_cordic #(
   parameter int CORDIC_ITERATIONS = chd_pkg::CORDIC_ITERATIONS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [chd_pkg::PROD_WIDTH-1:0] px,
   input  logic signed [chd_pkg::PROD_WIDTH-1:0] py,
   output logic                                  done,
   output logic [chd_pkg::HEADING_BITS-1:0]      heading
);

   localparam int CW = chd_pkg::CORDIC_WIDTH;
   localparam int ZW = chd_pkg::Z_WIDTH;
   localparam int DW = chd_pkg::DEG_WIDTH;
   localparam int IW = $clog2(CORDIC_ITERATIONS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ITER,
      ST_CONV
   } state_type;

   state_type                     state_ff, state_in;
   logic signed [CW-1:0]          x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]          z_ff, z_in;
   logic [IW-1:0]                 iter_ff, iter_in;
   logic                          done_ff, done_in;
   logic [chd_pkg::HEADING_BITS-1:0] heading_ff, heading_in;

   logic [chd_pkg::STEP_BITS-1:0] step;
   logic signed [CW-1:0]          x_start, dx, dy;
   logic signed [ZW-1:0]          ang;
   logic signed [DW-1:0]          deg_t, deg_a;

   assign step    = chd_pkg::STEP_BITS'(iter_ff);
   assign x_start = CW'(px) <<< chd_pkg::FRAC_BITS;
   assign dx      = y_ff >>> step;
   assign dy      = x_ff >>> step;
   assign ang     = ZW'(chd_pkg::atan_deg(step));

   always_comb begin
      // truncate toward zero, then fold into 0..359
      deg_t = DW'(z_ff >>> chd_pkg::FRAC_BITS);
      if (z_ff < 0 && z_ff[chd_pkg::FRAC_BITS-1:0] != '0) begin
         deg_t = deg_t + DW'(1);
      end
      deg_a = deg_t;
      if (deg_a < 0) begin
         deg_a = deg_a + chd_pkg::FULL_CIRCLE;
      end
      if (deg_a >= chd_pkg::FULL_CIRCLE) begin
         deg_a = deg_a - chd_pkg::FULL_CIRCLE;
      end
      if (deg_a < 0) begin
         deg_a = '0;
      end
   end

   always_comb begin
      state_in   = state_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      iter_in    = iter_ff;
      done_in    = 1'b0;
      heading_in = heading_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               iter_in = '0;
               if (px == '0 && py == '0) begin
                  heading_in = '0;
                  done_in    = 1'b1;
               end else if (px < 0) begin
                  // left half plane: turn by half a circle first
                  x_in     = -x_start;
                  y_in     = -(CW'(py) <<< chd_pkg::FRAC_BITS);
                  z_in     = (py >= 0) ? chd_pkg::HALF_TURN : -chd_pkg::HALF_TURN;
                  state_in = ST_ITER;
               end else begin
                  x_in     = x_start;
                  y_in     = CW'(py) <<< chd_pkg::FRAC_BITS;
                  z_in     = '0;
                  state_in = ST_ITER;
               end
            end
         end
         ST_ITER: begin
            if (y_ff >= 0) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + ang;
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - ang;
            end
            iter_in = iter_ff + IW'(1);
            if (iter_ff == IW'(CORDIC_ITERATIONS - 1)) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            heading_in = chd_pkg::HEADING_BITS'(deg_a);
            done_in    = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      iter_ff    <= iter_in;
      heading_ff <= heading_in;
   end

   assign done    = done_ff;
   assign heading = heading_ff;

endmodule

// ===== rtl/compass_heading_with_calibration_top.sv =====
// top level: min/max calibration, offset and range scaling, heading sequencer
`timescale 1ns / 1ps

// Compass heading from X/Y magnetometer samples with hard-iron calibration.
// Requests arrive on req_valid/req_stall with req_data (x_raw, y_raw); each
// request gives exactly one result on rsp_valid/rsp_stall with rsp_data
// (heading_deg, heading_valid). The csr_ channel writes calib_samples; it is
// always ready and should be written only while the block is idle.
// The first calib_samples requests only widen the per-axis min/max and return
// heading_valid 0, skipping the multiplier and the cordic. A heading request
// passes through the one shared 17x17 multiplier, used twice for the scaled
// vector, and then the cordic, which does one micro-rotation per cycle. A zero
// vector skips the rotations.
// One request is in work at a time; req_stall is low only while the sequencer
// is idle. A finished result sits in the output register while the next
// request is accepted; if the receiver stalls, the sequencer holds its next
// result until the output register frees up.
// Synchronous reset clears the calibration state, restores calib_samples to
// 3000 and drops rsp_valid.
module compass_heading_with_calibration_top #(
   parameter int CORDIC_ITERATIONS = chd_pkg::CORDIC_ITERATIONS,
   parameter int SAMPLE_WIDTH      = chd_pkg::SAMPLE_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  chd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output chd_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);

   localparam int SB = chd_pkg::SAMPLE_BITS;
   localparam int DB = chd_pkg::DIFF_BITS;
   localparam int PW = chd_pkg::PROD_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_START,
      ST_WAIT,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [15:0]             calib_ff, calib_in;
   logic [15:0]             count_ff, count_in;
   logic                    calibrated_ff, calibrated_in;
   logic signed [SB-1:0]    xmax_ff, xmax_in, xmin_ff, xmin_in;
   logic signed [SB-1:0]    ymax_ff, ymax_in, ymin_ff, ymin_in;
   logic signed [SB-1:0]    xs_ff, xs_in, ys_ff, ys_in;
   logic signed [DB-1:0]    xdiff_ff, xdiff_in, ydiff_ff, ydiff_in;
   logic signed [DB-1:0]    xrange_ff, xrange_in, yrange_ff, yrange_in;
   logic signed [PW-1:0]    px_ff, px_in, py_ff, py_in;
   chd_pkg::rsp_type        result_ff, result_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   chd_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic signed [DB-1:0]    xsum, ysum, xoff, yoff;
   logic signed [DB-1:0]    mul_a, mul_b;
   logic signed [PW-1:0]    mul_p;
   logic [15:0]             count_next;
   logic                    cordic_start, cordic_done;
   logic [chd_pkg::HEADING_BITS-1:0] cordic_heading;

   assign count_next = count_ff + 16'd1;

   // offsets truncate toward zero
   assign xsum = DB'(xmax_ff) + DB'(xmin_ff);
   assign ysum = DB'(ymax_ff) + DB'(ymin_ff);
   assign xoff = (xsum + $signed(DB'(xsum < 0))) >>> 1;
   assign yoff = (ysum + $signed(DB'(ysum < 0))) >>> 1;

   // one shared multiplier for both scaled components
   assign mul_a = (state_ff == ST_MUL_X) ? xdiff_ff : ydiff_ff;
   assign mul_b = (state_ff == ST_MUL_X) ? yrange_ff : xrange_ff;
   assign mul_p = PW'(mul_a) * PW'(mul_b);

   assign cordic_start = (state_ff == ST_START);

   chd_cordic #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .px      (px_ff),
      .py      (py_ff),
      .done    (cordic_done),
      .heading (cordic_heading)
   );

   always_comb begin
      state_in      = state_ff;
      calib_in      = calib_ff;
      count_in      = count_ff;
      calibrated_in = calibrated_ff;
      xmax_in       = xmax_ff;
      xmin_in       = xmin_ff;
      ymax_in       = ymax_ff;
      ymin_in       = ymin_ff;
      xs_in         = xs_ff;
      ys_in         = ys_ff;
      xdiff_in      = xdiff_ff;
      ydiff_in      = ydiff_ff;
      xrange_in     = xrange_ff;
      yrange_in     = yrange_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      if (csr_valid) begin
         calib_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               xs_in    = SB'(signed'(req_data.x_raw[SAMPLE_WIDTH-1:0]));
               ys_in    = SB'(signed'(req_data.y_raw[SAMPLE_WIDTH-1:0]));
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!calibrated_ff && count_ff < calib_ff) begin
               if (xs_ff > xmax_ff) xmax_in = xs_ff;
               if (xs_ff < xmin_ff) xmin_in = xs_ff;
               if (ys_ff > ymax_ff) ymax_in = ys_ff;
               if (ys_ff < ymin_ff) ymin_in = ys_ff;
               count_in      = count_next;
               calibrated_in = (count_next >= calib_ff);
               result_in     = '0;
               state_in      = ST_FINISH;
            end else begin
               calibrated_in = 1'b1;
               xdiff_in      = DB'(xs_ff) - xoff;
               ydiff_in      = DB'(ys_ff) - yoff;
               xrange_in     = DB'(xmax_ff) - DB'(xmin_ff);
               yrange_in     = DB'(ymax_ff) - DB'(ymin_ff);
               state_in      = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            px_in    = mul_p;
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            py_in    = mul_p;
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (cordic_done) begin
               result_in.heading_deg   = cordic_heading;
               result_in.heading_valid = 1'b1;
               state_in                = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         calib_ff      <= chd_pkg::CALIB_RESET;
         count_ff      <= '0;
         calibrated_ff <= 1'b0;
         xmax_ff       <= chd_pkg::MAX_RESET;
         xmin_ff       <= chd_pkg::MIN_RESET;
         ymax_ff       <= chd_pkg::MAX_RESET;
         ymin_ff       <= chd_pkg::MIN_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         calib_ff      <= calib_in;
         count_ff      <= count_in;
         calibrated_ff <= calibrated_in;
         xmax_ff       <= xmax_in;
         xmin_ff       <= xmin_in;
         ymax_ff       <= ymax_in;
         ymin_ff       <= ymin_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      xs_ff       <= xs_in;
      ys_ff       <= ys_in;
      xdiff_ff    <= xdiff_in;
      ydiff_ff    <= ydiff_in;
      xrange_ff   <= xrange_in;
      yrange_ff   <= yrange_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
